// ===== rtl/core/rgbfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbfs_pkg
// shared types, command codes and the gamma code table of the fade sequencer
// ----------------------------------------------------------------------------
package rgbfs_pkg;

  localparam int unsigned LIN_MAX  = 4095;
  localparam int unsigned OFF_SPAN = 100;
  localparam int unsigned MAX_BRIGHT = 10;
  // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for x below 81920
  localparam int unsigned DIV10_MUL   = 52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_STATE = 2'd2,
    CMD_EVENT = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        entry_index;
    logic              sequence_present;
    logic [7:0]        entry_red;
    logic [7:0]        entry_green;
    logic [7:0]        entry_blue;
    logic signed [15:0] entry_duration;
  } in_t;

  typedef struct packed {
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
  } out_t;

  typedef struct packed {
    logic [23:0]        color;
    logic signed [15:0] dur;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [15:0] elapsed;
    logic [15:0] span;
    logic [23:0] from_color;
    logic [23:0] to_color;
    logic [3:0]  bright;
  } calc_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] color;
  } calc_rsp_t;

  typedef logic [255:0][11:0] gtab_t;

  // true when v^11 * 255^5 >= c^5 * 4095^11
  function automatic logic reaches(input int unsigned v, input int unsigned c);
    logic [191:0] a;
    logic [191:0] b;
    a = 192'd1;
    b = 192'd1;
    for (int i = 0; i < 11; i++) a = a * 192'(v);
    for (int i = 0; i < 5; i++) a = a * 192'd255;
    for (int i = 0; i < 5; i++) b = b * 192'(c);
    for (int i = 0; i < 11; i++) b = b * 192'(LIN_MAX);
    return a >= b;
  endfunction

  // smallest 12-bit code whose decoded level reaches c
  function automatic gtab_t build_gamma();
    gtab_t t;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    for (int c = 0; c < 256; c++) begin
      lo = 0;
      hi = LIN_MAX;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (reaches(mid, c)) hi = mid;
        else lo = mid + 1;
      end
      t[c] = 12'(lo);
    end
    return t;
  endfunction

  localparam gtab_t GAMMA = build_gamma();

endpackage

// ===== rtl/core/rgbfs_fade_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbfs_fade_calc
// fade factor by bit-serial division, easing, gamma mix and bit-serial decode
// ----------------------------------------------------------------------------
module rgbfs_fade_calc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rgbfs_pkg::calc_req_t req,
  output rgbfs_pkg::calc_rsp_t rsp
);

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_DIV  = 7'b0000010,
    F_EASE = 7'b0000100,
    F_MUL  = 7'b0001000,
    F_ADD  = 7'b0010000,
    F_SCL  = 7'b0100000,
    F_DEC  = 7'b1000000
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] span_r, span_nxt;
  logic [16:0] g_r, g_nxt;
  logic [23:0] from_r, from_nxt;
  logic [23:0] to_r, to_nxt;
  logic [3:0]  br_r, br_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [11:0] e0_r, e0_nxt;
  logic        neg_r, neg_nxt;
  logic [28:0] prod_r, prod_nxt;
  logic [15:0] vb_r, vb_nxt;
  logic [11:0] vs_r, vs_nxt;
  logic [7:0]  c_r, c_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [23:0] col_r, col_nxt;
  logic        done_r, done_nxt;

  logic [16:0] dshift;
  logic        dge;
  logic [29:0] sq_lo;
  logic [16:0] dcomp;
  logic [33:0] sq_hi;
  logic [7:0]  cf, ct;
  logic [11:0] e0, e1, diff;
  logic [11:0] delta, v;
  logic [31:0] sprod;
  logic [7:0]  try_c;

  always_comb begin
    unique case (ch_r)
      2'd0:    begin cf = from_r[23:16]; ct = to_r[23:16]; end
      2'd1:    begin cf = from_r[15:8];  ct = to_r[15:8];  end
      default: begin cf = from_r[7:0];   ct = to_r[7:0];   end
    endcase
  end

  assign dshift = {rem_r, 1'b0};
  assign dge    = dshift >= {1'b0, span_r};
  assign sq_lo  = quo_r[14:0] * quo_r[14:0];
  assign dcomp  = 17'h10000 - {1'b0, quo_r};
  assign sq_hi  = dcomp * dcomp;
  assign e0     = rgbfs_pkg::GAMMA[cf];
  assign e1     = rgbfs_pkg::GAMMA[ct];
  assign diff   = (e1 < e0) ? (e0 - e1) : (e1 - e0);
  assign delta  = prod_r[27:16];
  assign v      = neg_r ? (e0_r - delta) : (e0_r + delta);
  assign sprod  = 32'(vb_r) * 32'(rgbfs_pkg::DIV10_MUL);
  assign try_c  = c_r | (8'd1 << bit_r);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    span_nxt  = span_r;
    g_nxt     = g_r;
    from_nxt  = from_r;
    to_nxt    = to_r;
    br_nxt    = br_r;
    ch_nxt    = ch_r;
    e0_nxt    = e0_r;
    neg_nxt   = neg_r;
    prod_nxt  = prod_r;
    vb_nxt    = vb_r;
    vs_nxt    = vs_r;
    c_nxt     = c_r;
    bit_nxt   = bit_r;
    col_nxt   = col_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (req.start) begin
          from_nxt = req.from_color;
          to_nxt   = req.to_color;
          br_nxt   = req.bright;
          span_nxt = req.span;
          rem_nxt  = req.elapsed;
          quo_nxt  = '0;
          cnt_nxt  = '0;
          ch_nxt   = '0;
          if (req.elapsed >= req.span) begin
            // factor saturates at one
            g_nxt     = 17'h10000;
            state_nxt = F_MUL;
          end else begin
            state_nxt = F_DIV;
          end
        end
      end
      F_DIV: begin
        rem_nxt = dge ? 16'(dshift - {1'b0, span_r}) : dshift[15:0];
        quo_nxt = {quo_r[14:0], dge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = F_EASE;
      end
      F_EASE: begin
        if (!quo_r[15]) g_nxt = 17'(sq_lo >> 15);
        else g_nxt = 17'h10000 - 17'(sq_hi >> 15);
        state_nxt = F_MUL;
      end
      F_MUL: begin
        e0_nxt    = e0;
        neg_nxt   = e1 < e0;
        prod_nxt  = g_r * diff;
        state_nxt = F_ADD;
      end
      F_ADD: begin
        vb_nxt    = 16'(v * br_r);
        state_nxt = F_SCL;
      end
      F_SCL: begin
        vs_nxt    = sprod[rgbfs_pkg::DIV10_SHIFT +: 12];
        c_nxt     = '0;
        bit_nxt   = 3'd7;
        state_nxt = F_DEC;
      end
      F_DEC: begin
        if (rgbfs_pkg::GAMMA[try_c] <= vs_r) c_nxt = try_c;
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          unique case (ch_r)
            2'd0:    col_nxt[23:16] = c_nxt;
            2'd1:    col_nxt[15:8]  = c_nxt;
            default: col_nxt[7:0]   = c_nxt;
          endcase
          if (ch_r == 2'd2) begin
            done_nxt  = 1'b1;
            state_nxt = F_IDLE;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = F_MUL;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    span_r <= span_nxt;
    g_r    <= g_nxt;
    from_r <= from_nxt;
    to_r   <= to_nxt;
    br_r   <= br_nxt;
    ch_r   <= ch_nxt;
    e0_r   <= e0_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
    vb_r   <= vb_nxt;
    vs_r   <= vs_nxt;
    c_r    <= c_nxt;
    bit_r  <= bit_nxt;
    col_r  <= col_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.color = col_r;

endmodule

// ===== rtl/core/rgb_led_fade_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_fade_sequencer
// plays event and state colour sequences from a step table, one tick per ms
// ----------------------------------------------------------------------------
//  channel  ports               direction  moves
//  in       in_valid/in_ready   input      command transaction (in_t)
//  out      out_valid/out_ready output     new led colour (out_t)
//  cfg      cfg_valid/cfg_ready input      brightness write, always ready
//
//  write, state and event commands are handled in T_IDLE, which keeps in_ready high
//  a tick that ends a segment, or finds nothing playing, first checks the cursor
//  and loads the next segment, then unless the span is zero runs a serial divide
//  and per channel the multiply, add and scale mix steps and a serial gamma decode
//  reset is synchronous active low; the step table is not cleared
//  a result waiting on out stalls only the next tick that changes colour
// ----------------------------------------------------------------------------
module rgb_led_fade_sequencer #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rgbfs_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rgbfs_pkg::out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_brightness
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef logic [255:0][AW-1:0] mtab_t;

  // table address of every 8-bit index, wrapped to the table depth
  function automatic mtab_t build_mod();
    mtab_t m;
    for (int i = 0; i < 256; i++) m[i] = AW'(i % TABLE_DEPTH);
    return m;
  endfunction

  localparam mtab_t IDX_MOD = build_mod();

  typedef enum logic [8:0] {
    T_IDLE  = 9'b000000001,
    T_CHK   = 9'b000000010,
    T_PICK  = 9'b000000100,
    T_LOAD0 = 9'b000001000,
    T_LOAD1 = 9'b000010000,
    T_LOAD2 = 9'b000100000,
    T_CALC  = 9'b001000000,
    T_WAIT  = 9'b010000000,
    T_EMIT  = 9'b100000000
  } tstate_t;

  rgbfs_pkg::entry_t mem [TABLE_DEPTH];
  rgbfs_pkg::entry_t rd_q_r;
  logic [AW-1:0]     rd_addr;

  tstate_t         state_r, state_nxt;
  logic [AW-1:0]   cursor_r, cursor_nxt;
  logic            active_r, active_nxt;
  logic [8:0]      state_start_r, state_start_nxt;
  logic [8:0]      event_start_r, event_start_nxt;
  logic [23:0]     from_r, from_nxt;
  logic [23:0]     to_r, to_nxt;
  logic [15:0]     elapsed_r, elapsed_nxt;
  logic [15:0]     span_r, span_nxt;
  logic [23:0]     shown_r, shown_nxt;
  logic [23:0]     color_r, color_nxt;
  logic signed [15:0] dur_r, dur_nxt;
  logic [3:0]      bright_r;
  logic            out_valid_r, out_valid_nxt;
  rgbfs_pkg::out_t out_data_r, out_data_nxt;

  rgbfs_pkg::calc_req_t calc_req;
  rgbfs_pkg::calc_rsp_t calc_rsp;

  logic          in_fire;
  logic [AW-1:0] cursor_inc;
  logic [15:0]   elapsed_inc;

  assign in_ready  = (state_r == T_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cursor_inc  = (cursor_r == AW'(TABLE_DEPTH - 1)) ? '0 : cursor_r + AW'(1);
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  // entry at the cursor, or the one after it while loading the fade target
  assign rd_addr = (state_r == T_LOAD1) ? cursor_inc : cursor_r;

  // step table: one write port for commands, one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && in_data.cmd == rgbfs_pkg::CMD_WRITE) begin
      mem[IDX_MOD[in_data.entry_index]] <= '{
        color: {in_data.entry_red, in_data.entry_green, in_data.entry_blue},
        dur:   in_data.entry_duration};
    end
    rd_q_r <= mem[rd_addr];
  end

  // brightness register, saturated at ten on use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= 4'd5;
    end else if (cfg_valid && cfg_ready) begin
      bright_r <= cfg_brightness;
    end
  end

  assign calc_req.start      = (state_r == T_CALC) && (span_r != '0);
  assign calc_req.elapsed    = elapsed_r;
  assign calc_req.span       = span_r;
  assign calc_req.from_color = from_r;
  assign calc_req.to_color   = to_r;
  assign calc_req.bright     = (bright_r > 4'(rgbfs_pkg::MAX_BRIGHT)) ?
                               4'(rgbfs_pkg::MAX_BRIGHT) : bright_r;

  rgbfs_fade_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (calc_req),
    .rsp   (calc_rsp)
  );

  always_comb begin
    state_nxt       = state_r;
    cursor_nxt      = cursor_r;
    active_nxt      = active_r;
    state_start_nxt = state_start_r;
    event_start_nxt = event_start_r;
    from_nxt        = from_r;
    to_nxt          = to_r;
    elapsed_nxt     = elapsed_r;
    span_nxt        = span_r;
    shown_nxt       = shown_r;
    color_nxt       = color_r;
    dur_nxt         = dur_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_fire) begin
          unique case (in_data.cmd)
            rgbfs_pkg::CMD_STATE:
              state_start_nxt = in_data.sequence_present ? {1'b1, in_data.entry_index} : '0;
            rgbfs_pkg::CMD_EVENT:
              event_start_nxt = in_data.sequence_present ? {1'b1, in_data.entry_index} : '0;
            rgbfs_pkg::CMD_TICK: begin
              // segment over or nothing playing: move on
              if (!active_r || elapsed_r >= span_r) begin
                state_nxt = active_r ? T_CHK : T_PICK;
              end else begin
                state_nxt = T_CALC;
              end
            end
            default: ;
          endcase
        end
      end
      T_CHK: begin
        // zero duration at the cursor ends the sequence
        state_nxt = (rd_q_r.dur == '0) ? T_PICK : T_LOAD0;
      end
      T_PICK: begin
        if (event_start_r[8]) begin
          cursor_nxt      = IDX_MOD[event_start_r[7:0]];
          active_nxt      = 1'b1;
          event_start_nxt = '0;
          state_nxt       = T_LOAD0;
        end else if (state_start_r[8]) begin
          cursor_nxt = IDX_MOD[state_start_r[7:0]];
          active_nxt = 1'b1;
          state_nxt  = T_LOAD0;
        end else begin
          // led off for a fixed idle span
          active_nxt  = 1'b0;
          from_nxt    = '0;
          to_nxt      = '0;
          elapsed_nxt = '0;
          span_nxt    = 16'(rgbfs_pkg::OFF_SPAN);
          state_nxt   = T_CALC;
        end
      end
      T_LOAD0: state_nxt = T_LOAD1;
      T_LOAD1: begin
        from_nxt  = rd_q_r.color;
        dur_nxt   = rd_q_r.dur;
        state_nxt = T_LOAD2;
      end
      T_LOAD2: begin
        elapsed_nxt = '0;
        if (dur_r > 0) begin
          to_nxt   = from_r;
          span_nxt = dur_r;
        end else begin
          // fade toward the next entry's colour
          to_nxt   = rd_q_r.color;
          span_nxt = 16'(-dur_r);
        end
        cursor_nxt = cursor_inc;
        state_nxt  = T_CALC;
      end
      T_CALC: begin
        if (span_r == '0) begin
          // zero span shows the start colour as is
          color_nxt   = from_r;
          elapsed_nxt = elapsed_inc;
          state_nxt   = T_EMIT;
        end else begin
          state_nxt = T_WAIT;
        end
      end
      T_WAIT: begin
        if (calc_rsp.done) begin
          color_nxt   = calc_rsp.color;
          elapsed_nxt = elapsed_inc;
          state_nxt   = T_EMIT;
        end
      end
      T_EMIT: begin
        if (color_r == shown_r) begin
          state_nxt = T_IDLE;
        end else if (!out_valid_r || out_ready) begin
          shown_nxt     = color_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{led_red: color_r[23:16], led_green: color_r[15:8],
                            led_blue: color_r[7:0]};
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= T_IDLE;
      cursor_r      <= '0;
      active_r      <= 1'b0;
      state_start_r <= '0;
      event_start_r <= '0;
      from_r        <= '0;
      to_r          <= '0;
      elapsed_r     <= '0;
      span_r        <= '0;
      shown_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cursor_r      <= cursor_nxt;
      active_r      <= active_nxt;
      state_start_r <= state_start_nxt;
      event_start_r <= event_start_nxt;
      from_r        <= from_nxt;
      to_r          <= to_nxt;
      elapsed_r     <= elapsed_nxt;
      span_r        <= span_nxt;
      shown_r       <= shown_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    color_r    <= color_nxt;
    dur_r      <= dur_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== tb/sv/tb_rgb_led_fade_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_led_fade_sequencer
// drives table writes, sequence selects and ticks into the fade sequencer,
// predicts every led color change in a behavioral model and checks each
// out transaction against it, under random stalls on both channels
// ----------------------------------------------------------------------------
module tb_rgb_led_fade_sequencer;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 100;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rgbfs_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  rgbfs_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [3:0] cfg_brightness;

  rgb_led_fade_sequencer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_brightness (cfg_brightness)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // --------------------------------------------------------------------------
  // behavioral copy of the sequencer
  // --------------------------------------------------------------------------
  int unsigned gamma_code [256];
  logic [23:0] tbl_color [256];
  int          tbl_dur [256];
  int unsigned play_ptr;
  bit          playing;
  int unsigned state_sel;   // bit 8 set when a state sequence is selected
  int unsigned event_sel;   // bit 8 set when an event is pending
  logic [23:0] seg_from;
  logic [23:0] seg_to;
  int unsigned seg_elapsed;
  int unsigned seg_span;
  logic [23:0] led_now;
  int unsigned model_bright;

  rgbfs_pkg::out_t pending_colors[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int wd_count;
  int sent_items;

  // v^11 * 255^5 >= c^5 * 4095^11, exact in 192 bits
  function automatic bit level_reached(int unsigned v, int unsigned c);
    logic [191:0] lhs;
    logic [191:0] rhs;
    lhs = 192'd1;
    rhs = 192'd1;
    for (int i = 0; i < 11; i++) lhs = lhs * 192'(v);
    for (int i = 0; i < 5; i++) lhs = lhs * 192'd255;
    for (int i = 0; i < 5; i++) rhs = rhs * 192'(c);
    for (int i = 0; i < 11; i++) rhs = rhs * 192'd4095;
    return lhs >= rhs;
  endfunction

  task automatic fill_gamma_codes();
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    for (int c = 0; c < 256; c++) begin
      lo = 0;
      hi = 4095;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (level_reached(mid, c)) hi = mid;
        else lo = mid + 1;
      end
      gamma_code[c] = lo;
    end
  endtask

  function automatic logic [7:0] linear_to_led(int unsigned v);
    logic [7:0] c;
    c = 0;
    for (int k = 1; k < 256; k++) if (gamma_code[k] <= v) c = 8'(k);
    return c;
  endfunction

  function automatic logic [7:0] blend_channel(logic [7:0] c0, logic [7:0] c1,
                                              int unsigned w, int unsigned b);
    longint unsigned e0;
    longint unsigned e1;
    longint unsigned v;
    e0 = 64'(gamma_code[c0]);
    e1 = 64'(gamma_code[c1]);
    if (e1 >= e0) v = e0 + ((64'(w) * (e1 - e0)) >> 16);
    else v = e0 - ((64'(w) * (e0 - e1)) >> 16);
    v = v * 64'(b) / 10;
    if (v > 4095) v = 4095;
    return linear_to_led(32'(v));
  endfunction

  function automatic void load_next_segment();
    seg_from    = tbl_color[play_ptr];
    seg_elapsed = 0;
    if (tbl_dur[play_ptr] > 0) begin
      seg_to   = seg_from;
      seg_span = tbl_dur[play_ptr];
    end else begin
      seg_to   = tbl_color[(play_ptr + 1) % 256];
      seg_span = -tbl_dur[play_ptr];
    end
    play_ptr = (play_ptr + 1) % 256;
  endfunction

  // one tick of the sequencer, returns 1 when the led color changes
  function automatic bit advance_led(output logic [23:0] color);
    longint unsigned f;
    int unsigned w;
    int unsigned d;
    int unsigned b;
    if (!playing || seg_elapsed >= seg_span) begin
      if (!playing || tbl_dur[play_ptr] == 0) begin
        if (event_sel[8]) begin
          play_ptr  = 32'(event_sel[7:0]);
          playing   = 1;
          event_sel = 0;
        end else if (state_sel[8]) begin
          play_ptr = 32'(state_sel[7:0]);
          playing  = 1;
        end else begin
          playing = 0;
        end
      end
      if (playing) begin
        load_next_segment();
      end else begin
        seg_from    = '0;
        seg_to      = '0;
        seg_elapsed = 0;
        seg_span    = rgbfs_pkg::OFF_SPAN;
      end
    end
    if (seg_span == 0) begin
      // zero-length segment shows the start color without brightness
      color = seg_from;
    end else begin
      f = (longint'(seg_elapsed) << 16) / seg_span;
      if (f > 65536) f = 65536;
      if (f < 32768) begin
        w = 32'((f * f) >> 15);
      end else begin
        d = 32'(65536 - f);
        w = 65536 - ((d * d) >> 15);
      end
      b = (model_bright > 10) ? 10 : model_bright;
      color[23:16] = blend_channel(seg_from[23:16], seg_to[23:16], w, b);
      color[15:8]  = blend_channel(seg_from[15:8], seg_to[15:8], w, b);
      color[7:0]   = blend_channel(seg_from[7:0], seg_to[7:0], w, b);
    end
    if (seg_elapsed < 65535) seg_elapsed++;
    if (color != led_now) begin
      led_now = color;
      return 1;
    end
    return 0;
  endfunction

  function automatic void apply_command(rgbfs_pkg::in_t x);
    logic [23:0] color;
    case (x.cmd)
      rgbfs_pkg::CMD_WRITE: begin
        tbl_color[x.entry_index] = {x.entry_red, x.entry_green, x.entry_blue};
        tbl_dur[x.entry_index]   = int'(x.entry_duration);
      end
      rgbfs_pkg::CMD_STATE:
        state_sel = x.sequence_present ? (32'h100 | 32'(x.entry_index)) : 0;
      rgbfs_pkg::CMD_EVENT:
        event_sel = x.sequence_present ? (32'h100 | 32'(x.entry_index)) : 0;
      default: begin
        if (advance_led(color)) pending_colors.push_back(rgbfs_pkg::out_t'(color));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // channel drivers
  // --------------------------------------------------------------------------
  // valid stays high between back-to-back transactions, lowered only on random gaps and in drain
  task automatic send_item(rgbfs_pkg::in_t x);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    apply_command(x);
  endtask

  task automatic send_cmd(rgbfs_pkg::cmd_t c, int idx, bit present, logic [23:0] rgb,
                          int dur);
    rgbfs_pkg::in_t x;
    x.cmd              = c;
    x.entry_index      = idx[7:0];
    x.sequence_present = present;
    x.entry_red        = rgb[23:16];
    x.entry_green      = rgb[15:8];
    x.entry_blue       = rgb[7:0];
    x.entry_duration   = dur[15:0];
    send_item(x);
  endtask

  task automatic tick(int n);
    for (int i = 0; i < n; i++)
      send_cmd(rgbfs_pkg::CMD_TICK, int'($urandom_range(255)), 1'($urandom_range(1)),
               24'($urandom), int'($urandom));
  endtask

  // wait until every predicted color has come out and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_brightness(int unsigned v);
    drain();
    cfg_valid      <= 1'b1;
    cfg_brightness <= v[3:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    model_bright = v;
  endtask

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // result checker
  always @(posedge clk) begin
    rgbfs_pkg::out_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected color %h %h %h", out_data.led_red, out_data.led_green,
                   out_data.led_blue);
      end else begin
        exp_c = pending_colors.pop_front();
        if (out_data.led_red != exp_c.led_red || out_data.led_green != exp_c.led_green ||
            out_data.led_blue != exp_c.led_blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch: expected %h %h %h, got %h %h %h",
                     exp_c.led_red, exp_c.led_green, exp_c.led_blue,
                     out_data.led_red, out_data.led_green, out_data.led_blue);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      wd_count <= 0;
    end else begin
      wd_count <= wd_count + 1;
      if (wd_count == WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // every table entry gets written so no sequence ever reads stale memory
  task automatic test_fill_table();
    for (int i = 0; i < 256; i++) begin
      if (i == 0) send_cmd(rgbfs_pkg::CMD_WRITE, i, 1'b0, 24'hFFFFFF, 0);
      else if (i == 1) send_cmd(rgbfs_pkg::CMD_WRITE, i, 1'b0, 24'h000000, 0);
      else send_cmd(rgbfs_pkg::CMD_WRITE, i, 1'b0, 24'($urandom), 0);
    end
  endtask

  // off period with nothing selected, then holds, fades and field extremes
  task automatic test_directed();
    tick(3);
    send_cmd(rgbfs_pkg::CMD_WRITE, 10, 1'b1, 24'hFF0000, 3);       // hold
    send_cmd(rgbfs_pkg::CMD_WRITE, 11, 1'b0, 24'h00FF00, -4);      // fade to next
    send_cmd(rgbfs_pkg::CMD_WRITE, 12, 1'b1, 24'h0000FF, 2);
    send_cmd(rgbfs_pkg::CMD_WRITE, 13, 1'b0, 24'hFFFFFF, 0);
    send_cmd(rgbfs_pkg::CMD_STATE, 10, 1'b1, 24'h0, 0);
    tick(12);
    // event on a terminator entry; it stays pending while the state sequence plays on
    send_cmd(rgbfs_pkg::CMD_EVENT, 13, 1'b1, 24'h0, 0);
    tick(6);
    // table wrap from the last entry back to the first
    send_cmd(rgbfs_pkg::CMD_WRITE, 255, 1'b1, 24'h80FF40, -3);
    send_cmd(rgbfs_pkg::CMD_WRITE, 0, 1'b0, 24'h10A0FF, 2);
    send_cmd(rgbfs_pkg::CMD_WRITE, 1, 1'b0, 24'h000000, 0);
    send_cmd(rgbfs_pkg::CMD_EVENT, 255, 1'b1, 24'h0, 0);
    send_cmd(rgbfs_pkg::CMD_STATE, 0, 1'b0, 24'h0, 0);             // clear state
    tick(8);
  endtask

  task automatic random_scenario();
    int len;
    int base;
    for (int s = 0; s < 2; s++) begin
      if ($urandom_range(99) < 80) begin
        len  = $urandom_range(1, 5);
        base = $urandom_range(255);
        for (int k = 0; k < len; k++)
          send_cmd(rgbfs_pkg::CMD_WRITE, (base + k) % 256, 1'($urandom_range(1)),
                   24'($urandom),
                   $urandom_range(1) ? int'($urandom_range(1, 12)) :
                                       -int'($urandom_range(1, 12)));
        send_cmd(rgbfs_pkg::CMD_WRITE, (base + len) % 256, 1'($urandom_range(1)),
                 24'($urandom), 0);
        send_cmd($urandom_range(1) ? rgbfs_pkg::CMD_STATE : rgbfs_pkg::CMD_EVENT, base,
                 $urandom_range(99) < 90, 24'($urandom), int'($urandom));
        tick($urandom_range(5, 40));
      end else begin
        // noise: any command with short durations so playback keeps moving
        send_cmd(rgbfs_pkg::cmd_t'($urandom_range(3)), int'($urandom_range(255)),
                 1'($urandom_range(1)), 24'($urandom), int'($urandom_range(80)) - 40);
      end
    end
  endtask

  task automatic test_random(int send_pct, int recv_pct, int n_items, int unsigned bright);
    int start_items;
    set_brightness(bright);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_items   = sent_items;
    while (sent_items - start_items < n_items) begin
      random_scenario();
    end
  endtask

  // the longest fade and hold values, played last since they never end here
  task automatic test_long_durations();
    send_cmd(rgbfs_pkg::CMD_WRITE, 200, 1'b1, 24'h7FFFFF, 32767);
    send_cmd(rgbfs_pkg::CMD_WRITE, 201, 1'b1, 24'hFF00FF, -32768);
    send_cmd(rgbfs_pkg::CMD_WRITE, 202, 1'b0, 24'h00FFFF, 0);
    send_cmd(rgbfs_pkg::CMD_EVENT, 201, 1'b1, 24'h0, 0);
    tick(1);
    send_cmd(rgbfs_pkg::CMD_EVENT, 0, 1'b0, 24'h0, 0);
    tick(30);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_brightness = 4'd5;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    mismatches     = 0;
    wd_count       = 0;
    sent_items     = 0;
    playing        = 0;
    play_ptr       = 0;
    state_sel      = 0;
    event_sel      = 0;
    seg_from       = '0;
    seg_to         = '0;
    seg_elapsed    = 0;
    seg_span       = 0;
    led_now        = '0;
    model_bright   = 5;
    fill_gamma_codes();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_table();
    set_brightness(10);
    test_directed();
    set_brightness(0);
    tick(4);
    set_brightness(15);
    send_cmd(rgbfs_pkg::CMD_STATE, 10, 1'b1, 24'h0, 0);
    tick(10);

    test_random(13, 64, 410, $urandom_range(1, 9));
    test_random(64, 13, 410, 10);
    test_random(0, 0, 410, $urandom_range(0, 15));
    test_long_durations();

    drain();
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
